// ===== src/sensor_frame_crc_check_decode_core_defines.svh =====
// Assertion helpers shared by the frame checker.
`ifndef SENSOR_FRAME_CRC_CHECK_DECODE_CORE_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECK_DECODE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sfcc_pkg.sv =====
package sfcc_pkg;

	localparam int DATA_BYTES = 6;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] MAG_MASK = 16'h7FFF;
	localparam logic [15:0] SIGN_BIT = 16'h8000;

	typedef logic [2:0] pos_t;

	localparam pos_t POS_HUM_HI   = 3'd2;
	localparam pos_t POS_HUM_LO   = 3'd3;
	localparam pos_t POS_TEMP_HI  = 3'd4;
	localparam pos_t POS_TEMP_LO  = 3'd5;
	localparam pos_t POS_CRC_LOW  = 3'(DATA_BYTES);
	localparam pos_t POS_CRC_HIGH = 3'(DATA_BYTES + 1);

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} frame_byte_t;

	typedef struct packed {
		logic               status;
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} frame_result_t;

	// One byte of the reflected CRC-16, shifted out LSB first.
	function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/sfcc_stream_if.sv =====
interface sfcc_in_if;
	import sfcc_pkg::*;

	logic        valid;
	logic        ready;
	frame_byte_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sfcc_out_if;
	import sfcc_pkg::*;

	logic          valid;
	logic          ready;
	frame_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/sensor_frame_crc_check_decode_core.sv =====
// A frame's result is written to the result register by the edge that moves its eighth byte
// from the input register; that byte may first wait there while an earlier result is not taken.
// Throughput: one byte per cycle; the input register and the result register are each
// single-entry, and the input side stalls only while a finished result waits on the output.
// Bytes that close no frame never wait on the output.
// Reset (arst_n low, asynchronous): byte position 0, running CRC 0xFFFF, both registers empty.
`include "sensor_frame_crc_check_decode_core_defines.svh"

module sensor_frame_crc_check_decode_core (
	input logic        clk,
	input logic        arst_n,
	sfcc_in_if.sink    frame_in,
	sfcc_out_if.source result_out
);
	import sfcc_pkg::*;

	logic          byte_valid_s1;
	frame_byte_t   byte_s1;

	pos_t          pos_q;
	logic [15:0]   crc_q;
	logic [15:0]   hum_q;
	logic [15:0]   temp_q;
	logic [7:0]    crc_low_q;

	logic          res_valid_q;
	frame_result_t res_q;

	pos_t          eff_pos;
	logic [15:0]   crc_base;
	logic [15:0]   crc_next;
	logic          closes_frame;
	logic          advance;
	logic [15:0]   rx_crc;
	logic [15:0]   mag;
	logic [15:0]   temp_signed;

	// A start flag restarts the count and the CRC before the byte is used.
	assign eff_pos      = byte_s1.frame_start ? '0 : pos_q;
	assign crc_base     = byte_s1.frame_start ? CRC_INIT : crc_q;
	assign crc_next     = crc_fold_byte(crc_base, byte_s1.data_byte);
	assign closes_frame = (eff_pos == POS_CRC_HIGH);
	assign advance      = byte_valid_s1 && (!closes_frame || !res_valid_q || result_out.ready);

	assign rx_crc      = {byte_s1.data_byte, crc_low_q};
	assign mag         = temp_q & MAG_MASK;
	assign temp_signed = ((temp_q & SIGN_BIT) != 16'h0000) ? (16'h0000 - mag) : mag;

	assign frame_in.ready     = !byte_valid_s1 || advance;
	assign result_out.valid   = res_valid_q;
	assign result_out.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			byte_valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			byte_s1 <= frame_in.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			hum_q     <= '0;
			temp_q    <= '0;
			crc_low_q <= '0;
		end else if (advance) begin
			case (eff_pos)
				POS_CRC_LOW: begin
					crc_low_q <= byte_s1.data_byte;
					pos_q     <= POS_CRC_HIGH;
					crc_q     <= crc_base;
				end
				POS_CRC_HIGH: begin
					pos_q <= '0;
					crc_q <= CRC_INIT;
				end
				default: begin
					crc_q <= crc_next;
					pos_q <= eff_pos + 3'd1;
					if (eff_pos == POS_HUM_HI) begin
						hum_q[15:8] <= byte_s1.data_byte;
					end
					if (eff_pos == POS_HUM_LO) begin
						hum_q[7:0] <= byte_s1.data_byte;
					end
					if (eff_pos == POS_TEMP_HI) begin
						temp_q[15:8] <= byte_s1.data_byte;
					end
					if (eff_pos == POS_TEMP_LO) begin
						temp_q[7:0] <= byte_s1.data_byte;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && closes_frame) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && closes_frame) begin
			if (rx_crc == crc_base) begin
				res_q.status             <= STATUS_OK;
				res_q.humidity_tenths    <= hum_q;
				res_q.temperature_tenths <= temp_signed;
			end else begin
				res_q.status             <= STATUS_BAD;
				res_q.humidity_tenths    <= '0;
				res_q.temperature_tenths <= '0;
			end
		end
	end

	`SFCC_ASSERT_SAME(a_bad_fields_zero,
		res_valid_q && (res_q.status == STATUS_BAD),
		(res_q.humidity_tenths == 16'h0000) && (res_q.temperature_tenths == 16'sh0000),
		"mismatch result carries nonzero fields")
	`SFCC_ASSERT_NEXT(a_close_gives_result, advance && closes_frame, res_valid_q,
		"closing byte produced no result")
	`SFCC_ASSERT_NEXT(a_close_rearms, advance && closes_frame,
		(pos_q == 3'd0) && (crc_q == CRC_INIT), "frame state not rearmed after result")
	`SFCC_ASSERT_SAME(a_stall_needs_byte, !frame_in.ready,
		byte_valid_s1 && closes_frame && res_valid_q,
		"input stalled without a waiting closing byte")
endmodule
